// File: design/sm3_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SM3 hash engine package
// Shared types, round constants and bit helpers for the SM3 hash engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenBytes   = 8;
  localparam int unsigned DigWords   = 8;

  localparam logic [31:0] T_LOW   = 32'h79CC4519;
  localparam logic [31:0] T_HIGH  = 32'h7A879D8A;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  localparam logic [31:0] IV [DigWords] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  // Source of the byte shifted into the block buffer
  typedef enum logic [1:0] {
    SRC_DATA,
    SRC_PAD,
    SRC_ZERO
  } byte_src_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic      shift_byte;
    byte_src_e byte_src;
    logic      shift_len;
    logic      len_add;
    logic      load_work;
    logic      round_en;
    logic [5:0] round_idx;
    logic      update_cv;
    logic      restart;
    logic [2:0] out_idx;
  } sm3_cmd_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] dbl;
    dbl = {x, x} << n;
    return dbl[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

  // Rotated round constant for round j
  function automatic logic [31:0] t_rot(input logic [5:0] j);
    return (j[5:4] == 2'b00) ? rotl(T_LOW, j[4:0]) : rotl(T_HIGH, j[4:0]);
  endfunction

endpackage
`default_nettype wire

// File: design/sm3_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SM3 stream interfaces
// Byte input channel and digest word output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sm3_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface sm3_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// File: design/sm3_hash_engine_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SM3 hash engine top level
// Streams message bytes in and returns the 256-bit SM3 digest as 8 words.
// ----------------------------------------------------------------------------
// One message byte is taken per cycle while the engine is idle. Every 64th
// byte starts a block compression (64 rounds on the single round unit plus
// one chain update) during which no input beat is accepted. An end-of-message
// beat appends the pad byte, then zero bytes one per cycle until the block
// holds 56 bytes, then the 64-bit length; this costs one or two
// compressions, after which the digest goes out as eight beats, word 0
// first, and the engine returns to the initial vector for the next message.
module sm3_hash_engine_top
  import sm3_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sm3_in_if.sink    in_ch,
  sm3_out_if.source out_ch
);

  sm3_cmd_t cmd;

  sm3_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_ch.valid),
    .byte_valid_i     (in_ch.byte_valid),
    .end_of_message_i (in_ch.end_of_message),
    .in_ready_o       (in_ch.ready),
    .out_valid_o      (out_ch.valid),
    .out_ready_i      (out_ch.ready),
    .word_index_o     (out_ch.word_index),
    .last_word_o      (out_ch.last_word),
    .cmd_o            (cmd)
  );

  sm3_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (in_ch.data_byte),
    .digest_word_o (out_ch.digest_word)
  );

endmodule
`default_nettype wire

// File: design/sm3_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SM3 datapath
// Block buffer / expansion window, bit length, chain value and one
// compression round per cycle.
// ----------------------------------------------------------------------------
module sm3_datapath
  import sm3_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire sm3_cmd_t cmd_i,
  input  wire logic [7:0] data_byte_i,
  output logic [31:0]   digest_word_o
);

  // 16-word window; word 0 sits in the top bits
  logic [511:0] msg_q, msg_d;
  logic [63:0]  len_q, len_d;
  logic [31:0]  cv_q [DigWords];
  logic [31:0]  a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;

  logic [7:0]  byte_in;
  logic [31:0] w0, w3, w4, w7, w10, w13, w_new;
  logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2;

  // Pick the byte to shift in
  always_comb begin
    case (cmd_i.byte_src)
      SRC_DATA: byte_in = data_byte_i;
      SRC_PAD:  byte_in = PAD_BYTE;
      SRC_ZERO: byte_in = 8'h00;
      default:  byte_in = 8'h00;
    endcase
  end

  // Window taps and message expansion
  assign w0  = msg_q[511:480];
  assign w3  = msg_q[415:384];
  assign w4  = msg_q[383:352];
  assign w7  = msg_q[287:256];
  assign w10 = msg_q[191:160];
  assign w13 = msg_q[95:64];
  assign w_new = perm1(w0 ^ w7 ^ rotl(w13, 5'd15)) ^ rotl(w3, 5'd7) ^ w10;

  // One compression round
  always_comb begin
    a12 = rotl(a_q, 5'd12);
    ss1 = rotl(a12 + e_q + t_rot(cmd_i.round_idx), 5'd7);
    ss2 = ss1 ^ a12;
    if (cmd_i.round_idx[5:4] == 2'b00) begin
      ff = a_q ^ b_q ^ c_q;
      gg = e_q ^ f_q ^ g_q;
    end else begin
      ff = (a_q & b_q) | (a_q & c_q) | (b_q & c_q);
      gg = (e_q & f_q) | (~e_q & g_q);
    end
    tt1 = ff + d_q + ss2 + (w0 ^ w4);
    tt2 = gg + h_q + ss1 + w0;
  end

  // Buffer update: byte shift, length append or round shift
  always_comb begin
    msg_d = msg_q;
    if (cmd_i.shift_byte) begin
      msg_d = {msg_q[503:0], byte_in};
    end else if (cmd_i.shift_len) begin
      msg_d = {msg_q[447:0], len_q};
    end else if (cmd_i.round_en) begin
      msg_d = {msg_q[479:0], w_new};
    end
  end

  always_comb begin
    len_d = len_q;
    if (cmd_i.restart) begin
      len_d = '0;
    end else if (cmd_i.len_add) begin
      len_d = len_q + 64'd8;
    end
  end

  always_ff @(posedge clk_i) begin
    msg_q <= msg_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  // Working variables: load from chain value, then advance one round
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_work) begin
      a_q <= cv_q[0]; b_q <= cv_q[1]; c_q <= cv_q[2]; d_q <= cv_q[3];
      e_q <= cv_q[4]; f_q <= cv_q[5]; g_q <= cv_q[6]; h_q <= cv_q[7];
    end else if (cmd_i.round_en) begin
      d_q <= c_q;
      c_q <= rotl(b_q, 5'd9);
      b_q <= a_q;
      a_q <= tt1;
      h_q <= g_q;
      g_q <= rotl(f_q, 5'd19);
      f_q <= e_q;
      e_q <= perm0(tt2);
    end
  end

  // Chain value: fold in the block result, or return to the initial vector
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= IV;
    end else if (cmd_i.restart) begin
      cv_q <= IV;
    end else if (cmd_i.update_cv) begin
      cv_q[0] <= cv_q[0] ^ a_q;
      cv_q[1] <= cv_q[1] ^ b_q;
      cv_q[2] <= cv_q[2] ^ c_q;
      cv_q[3] <= cv_q[3] ^ d_q;
      cv_q[4] <= cv_q[4] ^ e_q;
      cv_q[5] <= cv_q[5] ^ f_q;
      cv_q[6] <= cv_q[6] ^ g_q;
      cv_q[7] <= cv_q[7] ^ h_q;
    end
  end

  assign digest_word_o = cv_q[cmd_i.out_idx];

endmodule
`default_nettype wire

// File: design/sm3_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SM3 controller
// Sequences byte intake, padding, the 64 rounds and the digest beats.
// ----------------------------------------------------------------------------
module sm3_ctrl
  import sm3_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic byte_valid_i,
  input  wire logic end_of_message_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output logic [2:0] word_index_o,
  output logic      last_word_o,
  output sm3_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ROUND  = 3'd1;
  localparam logic [2:0] S_UPDATE = 3'd2;
  localparam logic [2:0] S_PAD80  = 3'd3;
  localparam logic [2:0] S_PADZ   = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  localparam logic [6:0] FillFull = 7'(BlockBytes);
  localparam logic [6:0] FillLast = 7'(BlockBytes - 1);
  localparam logic [6:0] FillLen  = 7'(BlockBytes - LenBytes);

  logic [2:0] state_q, state_d;
  logic [6:0] fill_q, fill_d;
  logic [5:0] rnd_q, rnd_d;
  logic [2:0] idx_q, idx_d;
  logic       end_q, end_d;
  logic       pad_q, pad_d;
  logic       last_q, last_d;

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = (state_q == S_EMIT);
  assign word_index_o = idx_q;
  assign last_word_o  = (idx_q == 3'd7);

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    rnd_d   = rnd_q;
    idx_d   = idx_q;
    end_d   = end_q;
    pad_d   = pad_q;
    last_d  = last_q;
    cmd_o   = '0;
    cmd_o.byte_src  = SRC_DATA;
    cmd_o.round_idx = rnd_q;
    cmd_o.out_idx   = idx_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          end_d = end_of_message_i;
          if (byte_valid_i) begin
            cmd_o.shift_byte = 1'b1;
            cmd_o.len_add    = 1'b1;
            fill_d = fill_q + 7'd1;
          end
          if (byte_valid_i && fill_q == FillLast) begin
            cmd_o.load_work = 1'b1;
            rnd_d   = '0;
            state_d = S_ROUND;
          end else if (end_of_message_i) begin
            state_d = S_PAD80;
          end
        end
      end
      S_ROUND: begin
        cmd_o.round_en = 1'b1;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd_o.update_cv = 1'b1;
        fill_d = '0;
        if (!end_q) begin
          state_d = S_IDLE;
        end else if (!pad_q) begin
          state_d = S_PAD80;
        end else if (last_q) begin
          idx_d   = '0;
          state_d = S_EMIT;
        end else begin
          state_d = S_PADZ;
        end
      end
      S_PAD80: begin
        cmd_o.shift_byte = 1'b1;
        cmd_o.byte_src   = SRC_PAD;
        fill_d = fill_q + 7'd1;
        pad_d  = 1'b1;
        if (fill_q == FillLast) begin
          cmd_o.load_work = 1'b1;
          rnd_d   = '0;
          state_d = S_ROUND;
        end else begin
          state_d = S_PADZ;
        end
      end
      S_PADZ: begin
        if (fill_q == FillLen) begin
          // append the bit length and close the final block
          cmd_o.shift_len = 1'b1;
          cmd_o.load_work = 1'b1;
          fill_d  = FillFull;
          last_d  = 1'b1;
          rnd_d   = '0;
          state_d = S_ROUND;
        end else begin
          cmd_o.shift_byte = 1'b1;
          cmd_o.byte_src   = SRC_ZERO;
          fill_d = fill_q + 7'd1;
          if (fill_q == FillLast) begin
            cmd_o.load_work = 1'b1;
            rnd_d   = '0;
            state_d = S_ROUND;
          end
        end
      end
      S_EMIT: begin
        if (out_ready_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            cmd_o.restart = 1'b1;
            end_d   = 1'b0;
            pad_d   = 1'b0;
            last_d  = 1'b0;
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      rnd_q   <= '0;
      idx_q   <= '0;
      end_q   <= 1'b0;
      pad_q   <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
      end_q   <= end_d;
      pad_q   <= pad_d;
      last_q  <= last_d;
    end
  end

  // Rounds run only on a full block
  a_round_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ROUND |-> fill_q == FillFull)
    else $error("compression running on a partial block");

  // Round counter steps by one inside a compression
  a_round_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND && rnd_q != 6'd63) |=>
      (state_q == S_ROUND && rnd_q == $past(rnd_q) + 6'd1))
    else $error("round sequence broken");

  // Length block only after the pad byte
  a_last_after_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_q |-> (pad_q && end_q))
    else $error("length appended without padding");

  // Digest beats start only after the final chain update
  a_emit_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && $past(state_q) != S_EMIT) |->
      ($past(state_q) == S_UPDATE && idx_q == 3'd0))
    else $error("digest emitted before final block");

endmodule
`default_nettype wire
